>>> sv/b32c_pkg.sv
// shared types, constants and functions for the base32 address crc16 checker
// no dependencies; used by b32c_core and the top level
package b32c_pkg;

	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] CRC_INIT      = 16'h0000;
	localparam logic [7:0]  VERSION_RESET = 8'h30;
	localparam logic [5:0]  CRC_BYTES     = 6'd33;
	localparam logic [5:0]  ADDR_CHARS    = 6'd56;
	localparam logic [5:0]  COUNT_MAX     = 6'd57;
	localparam logic [5:0]  LAST_BYTE     = 6'd35;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic       bad;
		logic [4:0] value;
	} sym_t;

	// upper-case rfc 4648 alphabet; anything else is flagged and packs as zero
	function automatic sym_t decode_char(input logic [7:0] c);
		sym_t s;
		s.bad = 1'b0;
		s.value = 5'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 5'(c - 8'h41);
		end else if (c >= 8'h32 && c <= 8'h37) begin
			s.value = 5'(c - 8'h32 + 8'd26);
		end else begin
			s.bad = 1'b1;
		end
		return s;
	endfunction

	// crc-16/xmodem update over one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/b32c_core.sv
// per-string state: base32 decode, byte packing, crc, version and length checks
// depends on b32c_pkg
module b32c_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  b32c_pkg::item_t    item,
	input  logic [7:0]         version,
	output logic               result
);

	logic [5:0]  char_count_q;
	logic [6:0]  bit_buffer_q;
	logic [2:0]  buffered_bits_q;
	logic [5:0]  byte_index_q;
	logic [15:0] running_crc_q;
	logic [7:0]  check_low_byte_q;
	logic        version_bad_q;
	logic        char_bad_q;

	b32c_pkg::sym_t sym;
	logic [3:0]  nb;
	logic [11:0] buf_w;
	logic [2:0]  sh;
	logic [7:0]  byte_w;
	logic [11:0] keep_mask;
	logic        byte_done;
	logic        decoding;
	logic        crc_match;

	logic [5:0]  char_count_d;
	logic [6:0]  bit_buffer_d;
	logic [2:0]  buffered_bits_d;
	logic [5:0]  byte_index_d;
	logic [15:0] running_crc_d;
	logic [7:0]  check_low_byte_d;
	logic        version_bad_d;
	logic        char_bad_d;

	always_comb begin
		sym = b32c_pkg::decode_char(item.character);
		decoding = char_count_q < b32c_pkg::ADDR_CHARS;
		nb = {1'b0, buffered_bits_q} + 4'd5;
		buf_w = {bit_buffer_q, sym.value};
		byte_done = decoding && (nb >= 4'd8);
		sh = 3'(nb - 4'd8);
		byte_w = 8'(buf_w >> sh);
		keep_mask = (12'd1 << sh) - 12'd1;
		crc_match = 1'b0;

		char_count_d = char_count_q;
		bit_buffer_d = bit_buffer_q;
		buffered_bits_d = buffered_bits_q;
		byte_index_d = byte_index_q;
		running_crc_d = running_crc_q;
		check_low_byte_d = check_low_byte_q;
		version_bad_d = version_bad_q;
		char_bad_d = char_bad_q | sym.bad;

		if (decoding) begin
			if (byte_done) begin
				bit_buffer_d = 7'(buf_w & keep_mask);
				buffered_bits_d = sh;
				if (byte_index_q == 6'd0 && byte_w != version) begin
					version_bad_d = 1'b1;
				end
				if (byte_index_q < b32c_pkg::CRC_BYTES) begin
					running_crc_d = b32c_pkg::crc_byte(running_crc_q, byte_w);
				end else if (byte_index_q == b32c_pkg::CRC_BYTES) begin
					check_low_byte_d = byte_w;
				end else if (byte_index_q == b32c_pkg::CRC_BYTES + 6'd1) begin
					crc_match = {byte_w, check_low_byte_q} == running_crc_q;
				end
				byte_index_d = byte_index_q + 6'd1;
			end else begin
				bit_buffer_d = 7'(buf_w);
				buffered_bits_d = 3'(nb);
			end
		end

		if (char_count_q < b32c_pkg::COUNT_MAX) begin
			char_count_d = char_count_q + 6'd1;
		end

		result = (char_count_d == b32c_pkg::ADDR_CHARS) && !char_bad_d
			&& !version_bad_d && crc_match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			bit_buffer_q <= '0;
			buffered_bits_q <= '0;
			byte_index_q <= '0;
			running_crc_q <= b32c_pkg::CRC_INIT;
			check_low_byte_q <= '0;
			version_bad_q <= 1'b0;
			char_bad_q <= 1'b0;
		end else if (step) begin
			if (item.last_char) begin
				// string ends: next item starts a fresh string
				char_count_q <= '0;
				bit_buffer_q <= '0;
				buffered_bits_q <= '0;
				byte_index_q <= '0;
				running_crc_q <= b32c_pkg::CRC_INIT;
				check_low_byte_q <= '0;
				version_bad_q <= 1'b0;
				char_bad_q <= 1'b0;
			end else begin
				char_count_q <= char_count_d;
				bit_buffer_q <= bit_buffer_d;
				buffered_bits_q <= buffered_bits_d;
				byte_index_q <= byte_index_d;
				running_crc_q <= running_crc_d;
				check_low_byte_q <= check_low_byte_d;
				version_bad_q <= version_bad_d;
				char_bad_q <= char_bad_d;
			end
		end
	end

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= b32c_pkg::COUNT_MAX)
		else $error("char count past saturation");

	a_byte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= b32c_pkg::LAST_BYTE)
		else $error("byte index beyond last address byte");

	a_bytes_track_chars: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= b32c_pkg::ADDR_CHARS |->
		(11'(byte_index_q) * 11'd8 + 11'(buffered_bits_q) == 11'(char_count_q) * 11'd5))
		else $error("packed bits disagree with character count");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_char |=> char_count_q == 6'd0 && byte_index_q == 6'd0)
		else $error("string state not cleared after last item");

endmodule

>>> sv/base32_address_crc16_checker_unit.sv
// top level: input register, string checker core, result register, version register
// depends on b32c_pkg and b32c_core
//
//  port group   direction  handshake            payload
//  in           to block   in_valid / in_stall   character, last_char
//  out          from block out_valid / out_stall valid_res
//  cfg          to block   cfg_valid / cfg_ready expected_version
//
// one character per cycle while in_stall is low; an item is held in the input register,
// is decoded and checked there, and its result (last character only) is registered
// in the result register as the item advances; that register drives out_valid.
// reset clears all string state and loads version 0x30; no clearing pass.
// in_stall rises only when a last character waits behind an undelivered result.
module base32_address_crc16_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] character,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       valid_res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] expected_version
);

	logic            valid_s1;
	b32c_pkg::item_t item_s1;
	logic            advance;
	logic            result;
	logic [7:0]      version_q;
	logic            out_valid_q;
	logic            valid_res_q;

	// a non-last item never produces a result, so only a last item can be held
	assign advance = valid_s1 && (!item_s1.last_char || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= b32c_pkg::VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			version_q <= expected_version;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.character <= character;
			item_s1.last_char <= last_char;
		end
	end

	b32c_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.version (version_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_char) begin
			valid_res_q <= result;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && item_s1.last_char && out_valid_q)
		else $error("input stalled without a held last item");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_char |=> out_valid)
		else $error("last item did not produce a result");

	a_plain_item_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.last_char |-> advance)
		else $error("non-last item held in input register");

endmodule
